// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file tmcw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ===== rtl/tmcw_pkg.sv =====
// Shared types, constants and codes of the text console writer.
`default_nettype none

package tmcw_pkg;

  localparam int COLUMNS_DEF      = 80;
  localparam int ROWS_DEF         = 25;
  localparam int MEMORY_WORDS_DEF = 8192;

  localparam int OFF_W  = 13;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHR_W  = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0720;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // control characters
  localparam logic [CHR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHR_W-1:0] CH_ENQ = 8'h05;
  localparam logic [CHR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHR_W-1:0] CH_DEL = 8'h7F;

  // register index (byte address bit 2)
  localparam logic REG_ATTR  = 1'b0;
  localparam logic REG_BLANK = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CHR_W-1:0] character;
    logic [OFF_W-1:0] cell_address;
    logic             end_of_write;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]  cursor_cell;
    logic [OFF_W-1:0]  window_start;
    logic              beep;
    logic [CELL_W-1:0] cell_data;
  } out_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CELL_W-1:0] blank;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/tmcw_ram.sv =====
// Single write port, single read port cell memory with registered read data.
`default_nettype none

module tmcw_ram #(
  parameter int DEPTH = tmcw_pkg::MEMORY_WORDS_DEF,
  parameter int WIDTH = tmcw_pkg::CELL_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tmcw_cfg.sv =====
// APB register file: character attribute and blank cell word.
`default_nettype none

module tmcw_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmcw_pkg::APB_AW-1:0] paddr,
  input  logic [tmcw_pkg::APB_DW-1:0] pwdata,
  output logic [tmcw_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tmcw_pkg::cfg_t              cfg_o
);

  import tmcw_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  logic [CELL_W-1:0] blank_q;

  // low address bits are not decoded; paddr[2] alone selects the register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q  <= RESET_ATTR;
      blank_q <= RESET_BLANK;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ATTR:  attr_q  <= pwdata[ATTR_W-1:0];
        REG_BLANK: blank_q <= pwdata[CELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ATTR:  prdata = APB_DW'(attr_q);
      REG_BLANK: prdata = APB_DW'(blank_q);
      default:   prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign cfg_o.attr  = attr_q;
  assign cfg_o.blank = blank_q;

endmodule

`default_nettype wire

// ===== rtl/tmcw_seq.sv =====
// Cursor state and memory sequencer: character handling, scroll, clear, read.
`default_nettype none

module tmcw_seq #(
  parameter int COLUMNS      = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS         = tmcw_pkg::ROWS_DEF,
  parameter int MEMORY_WORDS = tmcw_pkg::MEMORY_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  tmcw_pkg::in_t                   in_data_i,
  output logic                            idle_o,
  input  tmcw_pkg::cfg_t                  cfg_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output tmcw_pkg::out_t                  res_o,
  output logic                            mem_we_o,
  output logic [$clog2(MEMORY_WORDS)-1:0] mem_waddr_o,
  output logic [tmcw_pkg::CELL_W-1:0]     mem_wdata_o,
  output logic                            mem_re_o,
  output logic [$clog2(MEMORY_WORDS)-1:0] mem_raddr_o,
  input  logic [tmcw_pkg::CELL_W-1:0]     mem_rdata_i
);

  import tmcw_pkg::*;

  localparam int AW     = $clog2(MEMORY_WORDS);
  localparam int SCREEN = ROWS * COLUMNS;
  localparam int OFF_W1 = OFF_W + 1;

  localparam logic [OFF_W-1:0]  COLS_OFF     = OFF_W'(COLUMNS);
  localparam logic [OFF_W-1:0]  SCREEN_OFF   = OFF_W'(SCREEN);
  localparam logic [COL_W-1:0]  COLS_COL     = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [AW-1:0]     CNT_LAST_ALL = AW'(MEMORY_WORDS - 1);
  localparam logic [AW-1:0]     CNT_SCREEN   = AW'(SCREEN);
  localparam logic [AW-1:0]     CNT_LAST_COL = AW'(COLUMNS - 1);
  localparam logic [OFF_W1-1:0] COMPACT_LIM  = OFF_W1'(MEMORY_WORDS - SCREEN - COLUMNS);
  localparam logic [OFF_W1-1:0] MEM_END      = OFF_W1'(MEMORY_WORDS);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_COPY   = 7'b0001000,
    ST_BLANK  = 7'b0010000,
    ST_PUT    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [OFF_W-1:0] base_q, base_d;
  logic [CHR_W-1:0] char_q, char_d;
  logic             lf_q, lf_d;
  logic             put_q, put_d;
  logic             beep_q, beep_d;
  logic             sel_q, sel_d;
  logic [OFF_W-1:0] cursor_q, cursor_d;
  logic [OFF_W-1:0] window_q, window_d;
  logic [COL_W-1:0] column_q, column_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             imm;
  logic             bell;
  logic             scroll;
  logic             last_row;
  logic             wrap;
  logic             compact;
  logic             in_range;
  logic [OFF_W-1:0] col_off;
  logic [OFF_W-1:0] lf_step;
  logic [CHR_W-1:0] ch;

  function automatic logic [AW-1:0] mem_addr(input logic [OFF_W-1:0] off);
    return off[AW-1:0];
  endfunction

  assign ch       = in_data_i.character;
  assign last_row = (row_q == LAST_ROW);
  assign wrap     = (column_q >= COLS_COL);
  assign compact  = ({1'b0, window_q} >= COMPACT_LIM);
  assign in_range = ({1'b0, in_data_i.cell_address} < MEM_END);
  assign col_off  = OFF_W'(column_q);
  // line feed plus carriage return in one step
  assign lf_step  = COLS_OFF - col_off;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    char_d   = char_q;
    lf_d     = lf_q;
    put_d    = put_q;
    beep_d   = beep_q;
    sel_d    = sel_q;
    cursor_d = cursor_q;
    window_d = window_q;
    column_d = column_q;
    row_d    = row_q;

    imm         = 1'b0;
    bell        = 1'b0;
    scroll      = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = RESET_BLANK;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == CNT_LAST_ALL) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          beep_d = 1'b0;
          sel_d  = 1'b0;
          case (in_data_i.opcode)
            OP_WRITE: begin
              imm = 1'b1;
              case (ch)
                CH_NUL, CH_ENQ, CH_TAB, CH_VT: begin
                end
                CH_BEL: bell = 1'b1;
                CH_BS: begin
                  if (column_q != '0) begin
                    column_d    = column_q - COL_W'(1);
                    cursor_d    = cursor_q - OFF_W'(1);
                    mem_we_o    = 1'b1;
                    mem_waddr_o = mem_addr(cursor_q - OFF_W'(1));
                    mem_wdata_o = cfg_i.blank;
                  end
                end
                CH_LF, CH_FF: begin
                  lf_d  = (ch == CH_LF);
                  put_d = 1'b0;
                  if (!last_row) begin
                    row_d = row_q + ROW_W'(1);
                    if (ch == CH_LF) begin
                      cursor_d = cursor_q + lf_step;
                      column_d = '0;
                    end else begin
                      cursor_d = cursor_q + COLS_OFF;
                    end
                  end else begin
                    scroll = 1'b1;
                  end
                end
                CH_CR: begin
                  cursor_d = cursor_q - col_off;
                  column_d = '0;
                end
                CH_DEL: begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = mem_addr(cursor_q);
                  mem_wdata_o = cfg_i.blank;
                end
                default: begin
                  if (wrap && last_row) begin
                    // wrap on the last row: back up, scroll, then store
                    scroll   = 1'b1;
                    lf_d     = 1'b0;
                    put_d    = 1'b1;
                    char_d   = ch;
                    cursor_d = cursor_q - COLS_OFF;
                    column_d = column_q - COLS_COL;
                  end else begin
                    mem_we_o    = 1'b1;
                    mem_waddr_o = mem_addr(cursor_q);
                    mem_wdata_o = {cfg_i.attr, ch};
                    cursor_d    = cursor_q + OFF_W'(1);
                    if (wrap) begin
                      row_d    = row_q + ROW_W'(1);
                      column_d = column_q - COLS_COL + COL_W'(1);
                    end else begin
                      column_d = column_q + COL_W'(1);
                    end
                  end
                end
              endcase
            end
            OP_CLEAR: begin
              state_d  = ST_CLEAR;
              cnt_d    = '0;
              cursor_d = '0;
              window_d = '0;
              column_d = '0;
              row_d    = '0;
            end
            OP_READ: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = in_data_i.cell_address[AW-1:0];
              sel_d       = in_range;
              state_d     = ST_FINISH;
            end
            default: imm = 1'b1;
          endcase

          if (scroll) begin
            imm   = 1'b0;
            cnt_d = '0;
            if (compact) begin
              state_d = ST_COPY;
              base_d  = window_q;
            end else begin
              state_d = ST_BLANK;
              base_d  = window_q + SCREEN_OFF;
            end
          end

          if (imm) begin
            res_valid_o = 1'b1;
            if (!res_ready_i) begin
              state_d = ST_FINISH;
              beep_d  = bell;
            end
          end
        end
      end

      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = cfg_i.blank;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == CNT_LAST_ALL) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end
      end

      ST_COPY: begin
        // read runs one word ahead of the write
        if (cnt_q != CNT_SCREEN) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = mem_addr(base_q + OFF_W'(cnt_q));
        end
        if (cnt_q != '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cnt_q - AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == CNT_SCREEN) begin
          cnt_d    = '0;
          base_d   = SCREEN_OFF;
          cursor_d = cursor_q - window_q;
          window_d = '0;
          state_d  = ST_BLANK;
        end
      end

      ST_BLANK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = mem_addr(base_q + OFF_W'(cnt_q));
        mem_wdata_o = cfg_i.blank;
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == CNT_LAST_COL) begin
          cnt_d    = '0;
          window_d = window_q + COLS_OFF;
          if (lf_q) begin
            cursor_d = cursor_q + lf_step;
            column_d = '0;
          end else begin
            cursor_d = cursor_q + COLS_OFF;
          end
          state_d = put_q ? ST_PUT : ST_FINISH;
        end
      end

      ST_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = mem_addr(cursor_q);
        mem_wdata_o = {cfg_i.attr, char_q};
        cursor_d    = cursor_q + OFF_W'(1);
        column_d    = column_q + COL_W'(1);
        state_d     = ST_FINISH;
      end

      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.cursor_cell  = cursor_d;
    res_o.window_start = window_d;
    res_o.beep         = (state_q == ST_IDLE) ? bell : beep_q;
    res_o.cell_data    = ((state_q == ST_FINISH) && sel_q) ? mem_rdata_i : '0;
  end

  assign idle_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      lf_q     <= 1'b0;
      put_q    <= 1'b0;
      beep_q   <= 1'b0;
      sel_q    <= 1'b0;
      cursor_q <= '0;
      window_q <= '0;
      column_q <= '0;
      row_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lf_q     <= lf_d;
      put_q    <= put_d;
      beep_q   <= beep_d;
      sel_q    <= sel_d;
      cursor_q <= cursor_d;
      window_q <= window_d;
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    char_q <= char_d;
  end

endmodule

`default_nettype wire

// ===== rtl/text_mode_console_writer_top.sv =====
// Top level of the text console writer: sequencer, cell memory, registers, output stage.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//  out      | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//  config   | input     | APB psel/penable/pready | pwdata / prdata
//
//  Plain characters and control codes without scroll are handled in the idle state.
//  Cell read: registered memory read, returned from the finish state. Line feed
//  on the last row: blank fill of the new row, after a copy of the screen to
//  base when the window is compacted, then the store of a wrapped printable.
//  Clear: blank fill of all memory. After reset a clearing pass fills the memory
//  with the blank word; in_stall_o stays high until it ends. The output register
//  holds one finished transaction, so a new one is accepted while it waits.
`default_nettype none

module text_mode_console_writer_top #(
  parameter int COLUMNS      = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS         = tmcw_pkg::ROWS_DEF,
  parameter int MEMORY_WORDS = tmcw_pkg::MEMORY_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tmcw_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tmcw_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmcw_pkg::APB_AW-1:0] paddr,
  input  logic [tmcw_pkg::APB_DW-1:0] pwdata,
  output logic [tmcw_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  import tmcw_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);

  cfg_t              cfg;
  logic              idle;
  logic              res_valid;
  logic              res_ready;
  out_t              res;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              out_valid_q;
  out_t              out_data_q;

  tmcw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmcw_seq #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .idle_o      (idle),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tmcw_ram #(
    .DEPTH (MEMORY_WORDS),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Only an idle sequencer takes a transaction; stall does not depend on valid.
  assign in_stall_o = !idle;

  // Output register: takes a result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/tmcw_checker.sv =====
// Port-level checks of the text console writer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tmcw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_i,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input tmcw_pkg::out_t out_data_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_i;
  assign out_acc = out_valid_i && !out_stall_i;
  assign pend_d  = pend_q + 2'(in_acc) - 2'(out_acc);

  // transactions accepted whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))
  `ASSERT_IMPL(a_no_orphan, clk_i, rst_ni, out_valid_i, pend_q != 2'd0)
  `ASSERT_IMPL(a_pend_bound, clk_i, rst_ni, in_acc, pend_q == 2'd0 || pend_q == 2'd1)
  `ASSERT_IMPL(a_cursor_in_win, clk_i, rst_ni, out_valid_i, out_data_i.cursor_cell >= out_data_i.window_start)
  `ASSERT_IMPL(a_beep_no_data, clk_i, rst_ni, out_valid_i && out_data_i.beep, out_data_i.cell_data == '0)

endmodule

bind text_mode_console_writer_top tmcw_checker u_tmcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

// ===== tb/sv/text_mode_console_writer_top_tb.sv =====
// Self-checking testbench of the text console writer: random character traffic vs. a cell model.
`default_nettype none

module text_mode_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmcw_pkg::*;

  // Geometry of the instance under test (defaults of the top level).
  localparam int COLUMNS   = COLUMNS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int MEM_WORDS = MEMORY_WORDS_DEF;
  localparam int SCREEN    = ROWS * COLUMNS;

  localparam logic [OFF_W-1:0] COLS_OFF = OFF_W'(COLUMNS);
  localparam logic [COL_W-1:0] COLS_COL = COL_W'(COLUMNS);

  // The one opcode the package leaves unnamed; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Register byte addresses: register index sits on paddr[2].
  localparam logic [APB_AW-1:0] ADDR_ATTR  = {REG_ATTR, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_BLANK = {REG_BLANK, 2'b00};

  localparam int NUM_PHASES       = 5;
  localparam int PHASE_ITEMS      = 185;
  localparam int IDLE_SETTLE      = 32;      // cycles let pass once nothing is expected
  localparam int DRAIN_LIMIT      = 40000;   // > two clears in flight plus stalls
  localparam int LONG_HOLD_AT     = 400;     // result count at which the long hold starts
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS       = 300_000_000;

  // ------------------------------------------------------------------------
  // DUT signals; every input is known from time zero.
  // ------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  text_mode_console_writer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ------------------------------------------------------------------------
  // Console model: own copy of the cell memory, cursor, window and registers.
  // Updated on every accepted input transaction; each transaction pushes the
  // status it must produce onto status_q.
  // ------------------------------------------------------------------------
  logic [CELL_W-1:0] cell_img [MEM_WORDS];
  logic [OFF_W-1:0]  cur_q;
  logic [OFF_W-1:0]  win_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  line_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CELL_W-1:0] blank_q;

  out_t status_q [$];   // expected status of transactions still in the block
  in_t  cmd_q [$];      // transactions waiting to be offered

  int   mismatch_cnt = 0;
  int   rx_cnt       = 0;
  int   pushed       = 0;
  logic quiet        = 1'b0;   // no idling on either side in the last phase

  // Fill the whole memory with the blank word and home everything.
  task automatic wipe_screen();
    int k;
    for (k = 0; k < MEM_WORDS; k++) cell_img[OFF_W'(k)] = blank_q;
    cur_q  = '0;
    win_q  = '0;
    col_q  = '0;
    line_q = '0;
  endtask

  // Line feed: next row, or scroll the window (compacting to base first when
  // the blank row would run off the end of memory).
  task automatic advance_line();
    int k;
    int w;
    if (int'(line_q) + 1 < ROWS) begin
      line_q = line_q + ROW_W'(1);
      cur_q  = cur_q + COLS_OFF;
    end else begin
      w = int'(win_q);
      if (w + SCREEN + COLUMNS >= MEM_WORDS) begin
        // source is always above destination, forward copy is safe
        for (k = 0; k < SCREEN; k++)
          cell_img[OFF_W'(k)] = cell_img[OFF_W'((w + k) % MEM_WORDS)];
        cur_q = cur_q - win_q;
        win_q = '0;
        w     = 0;
      end
      for (k = 0; k < COLUMNS; k++) cell_img[OFF_W'((w + SCREEN + k) % MEM_WORDS)] = blank_q;
      win_q = win_q + COLS_OFF;
      cur_q = cur_q + COLS_OFF;
    end
  endtask

  task automatic return_carriage();
    cur_q = cur_q - OFF_W'(col_q);
    col_q = '0;
  endtask

  task automatic apply_console_item(input in_t it);
    out_t st;
    logic bell;
    bell         = 1'b0;
    st.cell_data = '0;
    case (it.opcode)
      OP_WRITE: begin
        case (it.character)
          CH_NUL, CH_ENQ, CH_TAB, CH_VT: ;
          CH_BEL: bell = 1'b1;
          CH_BS: begin
            // nothing at column zero
            if (col_q != '0) begin
              col_q           = col_q - COL_W'(1);
              cur_q           = cur_q - OFF_W'(1);
              cell_img[cur_q] = blank_q;
            end
          end
          CH_LF: begin
            advance_line();
            return_carriage();
          end
          CH_FF:  advance_line();
          CH_CR:  return_carriage();
          CH_DEL: cell_img[cur_q] = blank_q;
          default: begin
            // a printable past the last column wraps to the next line first
            if (col_q >= COLS_COL) begin
              col_q = col_q - COLS_COL;
              cur_q = cur_q - COLS_OFF;
              advance_line();
            end
            cell_img[cur_q] = {attr_q, it.character};
            cur_q           = cur_q + OFF_W'(1);
            col_q           = col_q + COL_W'(1);
          end
        endcase
      end
      OP_CLEAR: wipe_screen();
      OP_READ:  st.cell_data = cell_img[it.cell_address];
      default: ;
    endcase
    st.cursor_cell  = cur_q;
    st.window_start = win_q;
    st.beep         = bell;
    status_q.push_back(st);
  endtask

  // ------------------------------------------------------------------------
  // Driver: offers cmd_q in order, holds the payload while stalled, and
  // inserts random idle bursts between transactions.
  // ------------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_console_item(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap     <= tx_gap - 1;
        end else if (cmd_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_q.pop_front();
          if (!quiet && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks every accepted status against the oldest expectation and
  // drives out_stall_i. Once, after result LONG_HOLD_AT, the receiver holds off so
  // the output register and the sequencer fill and in_stall_o rises.
  // ------------------------------------------------------------------------
  int   rx_stall_left = 0;
  out_t want;

  task automatic check_field(input string fname, input logic [15:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt = mismatch_cnt + 1;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t ns: unexpected transaction, expected none actual %h",
                   $time, out_data_o);
        end else begin
          want = status_q.pop_front();
          check_field("cursor_cell", 16'(want.cursor_cell), 16'(out_data_o.cursor_cell));
          check_field("window_start", 16'(want.window_start), 16'(out_data_o.window_start));
          check_field("beep", 16'(want.beep), 16'(out_data_o.beep));
          check_field("cell_data", want.cell_data, out_data_o.cell_data);
        end
        rx_cnt <= rx_cnt + 1;
      end
      if (out_valid_o && !out_stall_i && rx_cnt == LONG_HOLD_AT) begin
        out_stall_i   <= 1'b1;
        rx_stall_left <= LONG_HOLD_CYCLES;
      end else if (rx_stall_left != 0) begin
        out_stall_i   <= 1'b1;
        rx_stall_left <= rx_stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i   <= 1'b1;
        rx_stall_left <= $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] op, input logic [CHR_W-1:0] ch,
                          input logic [OFF_W-1:0] addr, input logic eow);
    in_t it;
    it.opcode       = op;
    it.character    = ch;
    it.cell_address = addr;
    it.end_of_write = eow;
    cmd_q.push_back(it);
    // codes the block merely ignores do not count toward the phase size
    if (!(op == OP_UNUSED ||
          (op == OP_WRITE && ch inside {CH_NUL, CH_ENQ, CH_TAB, CH_VT})))
      pushed = pushed + 1;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_console_regs(input logic [ATTR_W-1:0] attr, input logic [CELL_W-1:0] blank);
    apb_write(ADDR_ATTR, APB_DW'(attr));
    apb_write(ADDR_BLANK, APB_DW'(blank));
    attr_q  = attr;
    blank_q = blank;
  endtask

  // Block is idle once nothing is queued, offered or expected.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid_i || status_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  // One burst of traffic: mostly well-formed write calls (text lines and runs
  // of line feeds that drive the window through scroll and compaction), plus
  // cell reads and raw noise over every field.
  task automatic gen_burst();
    int               kind;
    int               n;
    int               k;
    int               r;
    logic [CHR_W-1:0] ch;
    logic [OFF_W-1:0] addr;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // text line; long ones run past the last column and wrap
      r = $urandom_range(0, 99);
      if (r < 60)      n = $urandom_range(0, 6);
      else if (r < 85) n = $urandom_range(7, 40);
      else             n = $urandom_range(75, 100);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4)       ch = CH_BS;
        else if (r < 6)  ch = CH_DEL;
        else if (r < 8)  ch = CH_BEL;
        else if (r < 10) ch = CH_CR;
        else if (r < 75) ch = CHR_W'($urandom_range(8'h20, 8'h7E));
        else if (r < 92) ch = CHR_W'($urandom_range(8'h80, 8'hFF));
        else             ch = CHR_W'($urandom_range(0, 255));
        push_cmd(OP_WRITE, ch, OFF_W'($urandom), 1'b0);
      end
      r = $urandom_range(0, 9);
      if (r < 6) begin
        push_cmd(OP_WRITE, CH_LF, OFF_W'($urandom), 1'b1);
      end else if (r < 7) begin
        push_cmd(OP_WRITE, CH_CR, OFF_W'($urandom), 1'b0);
        push_cmd(OP_WRITE, CH_LF, OFF_W'($urandom), 1'b1);
      end else if (r < 8) begin
        push_cmd(OP_WRITE, CH_FF, OFF_W'($urandom), 1'b1);
      end else begin
        push_cmd(OP_WRITE, CHR_W'($urandom_range(8'h20, 8'h7E)), OFF_W'($urandom), 1'b1);
      end
    end else if (kind < 72) begin
      // run of empty lines
      n = $urandom_range(3, 20);
      for (k = 0; k < n; k++)
        push_cmd(OP_WRITE, ($urandom_range(0, 9) < 7) ? CH_LF : CH_FF, OFF_W'($urandom),
                 1'($urandom_range(0, 1)));
    end else if (kind < 87) begin
      // noise; clears are costly, so half of them become writes
      r = $urandom_range(0, 3);
      if (2'(r) == OP_CLEAR && $urandom_range(0, 1) == 0) r = int'(OP_WRITE);
      push_cmd(2'(r), CHR_W'($urandom), OFF_W'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      // reads: anywhere, around the compaction area, or around the window
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 2);
        if (r == 0)      addr = OFF_W'($urandom);
        else if (r == 1) addr = OFF_W'($urandom_range(0, SCREEN + COLUMNS - 1));
        else             addr = win_q + OFF_W'($urandom_range(0, SCREEN + COLUMNS - 1));
        push_cmd(OP_READ, CHR_W'($urandom), addr, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence: reset, directed transactions, random phases, drain, verdict.
  // ------------------------------------------------------------------------
  initial begin
    int ph;
    int k;
    attr_q  = RESET_ATTR;
    blank_q = RESET_BLANK;
    wipe_screen();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset register values. The block is still
    // running its clearing pass; the handshake holds these off until it ends.
    @(negedge clk_i);
    push_cmd(OP_WRITE, 8'h41, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, 8'h42, 13'h1FFF, 1'b0);
    push_cmd(OP_WRITE, CH_BEL, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_NUL, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_ENQ, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_TAB, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_VT, 13'h0000, 1'b1);
    push_cmd(OP_WRITE, CH_BS, 13'h0000, 1'b0);     // erases previous cell
    push_cmd(OP_WRITE, CH_CR, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_BS, 13'h0000, 1'b0);     // at column zero: no effect
    push_cmd(OP_WRITE, CH_DEL, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, 8'h80, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, 8'hFF, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_LF, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, CH_FF, 13'h0000, 1'b1);
    push_cmd(OP_READ, 8'h00, 13'h0000, 1'b0);
    push_cmd(OP_READ, 8'hFF, 13'h0001, 1'b0);
    push_cmd(OP_READ, 8'h00, 13'h1FFF, 1'b1);
    push_cmd(OP_UNUSED, 8'hFF, 13'h1FFF, 1'b1);
    push_cmd(OP_CLEAR, 8'h00, 13'h0000, 1'b0);
    push_cmd(OP_READ, 8'h00, 13'h0000, 1'b0);
    push_cmd(OP_WRITE, 8'h20, 13'h0000, 1'b1);

    // Random phases; registers change only while the block is idle.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:              set_console_regs(8'h00, 16'h0000);
        1:              set_console_regs(8'hFF, 16'hFFFF);
        NUM_PHASES - 1: set_console_regs(RESET_ATTR, RESET_BLANK);
        default:        set_console_regs(ATTR_W'($urandom), CELL_W'($urandom));
      endcase
      @(negedge clk_i);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      pushed = 0;
      while (pushed < PHASE_ITEMS) gen_burst();
    end

    // Drain: everything accepted, then the remaining statuses, then settle.
    while (cmd_q.size() != 0 || in_valid_i) @(negedge clk_i);
    for (k = 0; k < DRAIN_LIMIT && status_q.size() != 0; k++) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
    if (status_q.size() != 0) begin
      mismatch_cnt = mismatch_cnt + 1;
      $display("%0t ns: %0d expected transactions never arrived", $time, status_q.size());
    end
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
